// File: src/sdls_pkg.sv
// Shared types and constants for the splat dominant layer sampler.
// No dependencies.
`default_nettype none
package sdls_pkg;

   localparam int CsrDataW  = 32;
   localparam int CsrIndexW = 3;

   localparam logic [CsrIndexW-1:0] CsrOriginX   = 3'd0;
   localparam logic [CsrIndexW-1:0] CsrOriginZ   = 3'd1;
   localparam logic [CsrIndexW-1:0] CsrWorldSize = 3'd2;
   localparam logic [CsrIndexW-1:0] CsrMapWidth  = 3'd3;
   localparam logic [CsrIndexW-1:0] CsrMapHeight = 3'd4;

   localparam logic OpWrite  = 1'b0;
   localparam logic OpSample = 1'b1;

   typedef struct packed {
      logic               operation;
      logic [15:0]        texel_index;
      logic [31:0]        texel_rgba;
      logic signed [31:0] world_x;
      logic signed [31:0] world_z;
   } req_type;

   typedef struct packed {
      logic        inside_res;
      logic [1:0]  dominant_layer;
      logic [16:0] dominant_weight;
   } rsp_type;

   typedef struct packed {
      logic        v;
      logic        op;
      logic        hit;
      logic [15:0] idx;
      logic [31:0] rgba;
   } ctl_type;

endpackage
`default_nettype wire

// File: src/splat_dominant_layer_sampler_unit.sv
// Splat dominant layer sampler: top level, pipelined texel store and sampler.
// Depends on sdls_pkg and sdls_ram.
//
// Usage:
//  - req channel (valid/ready) carries write beats (store one RGBA texel) and
//    sample beats (world X,Z point). Accepts one beat per cycle while ready.
//  - rsp channel returns one beat per sample, in order; writes return none.
//  - csr port writes origin, world size and map size; write only while idle.
//  - From sample accept to rsp_valid a beat passes one offset stage, one
//    multiply stage, nine restoring-divide stages for the texel coordinate,
//    address, store read, channel compare, seventeen divide stages for the
//    weight, and the output register. One beat per cycle when not stalled.
//  - Writes reach the store at the same stage as sample reads, so beats keep
//    their order against the store.
//  - Reset clears the registers to their defaults and empties the pipeline;
//    the texel store is not cleared and must be written before it is read.
//  - When rsp stalls, the pipeline keeps moving as long as its last stage
//    holds no sample; otherwise it stops as a whole, losing nothing.
`default_nettype none
module splat_dominant_layer_sampler_unit #(
   parameter int MAX_MAP_DIM = 256
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_valid,
   output logic                             req_ready,
   input  wire sdls_pkg::req_type           req_data,
   output logic                             rsp_valid,
   input  wire                              rsp_ready,
   output sdls_pkg::rsp_type                rsp_data,
   input  wire                              csr_we,
   input  wire [sdls_pkg::CsrIndexW-1:0]    csr_index,
   input  wire [sdls_pkg::CsrDataW-1:0]     csr_wdata
);
   localparam logic [8:0] MaxDim = (MAX_MAP_DIM > 511) ? 9'd511 : 9'(MAX_MAP_DIM);
   localparam int CoordBits  = 9;
   localparam int WeightBits = 17;

   logic [31:0] origin_x_ff, origin_z_ff;
   logic [30:0] world_size_ff;
   logic [8:0]  map_width_ff, map_height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff   <= '0;
         origin_z_ff   <= '0;
         world_size_ff <= 31'd65536;
         map_width_ff  <= 9'd256;
         map_height_ff <= 9'd256;
      end else if (csr_we) begin
         unique case (csr_index)
            sdls_pkg::CsrOriginX:   origin_x_ff   <= csr_wdata;
            sdls_pkg::CsrOriginZ:   origin_z_ff   <= csr_wdata;
            sdls_pkg::CsrWorldSize: world_size_ff <= csr_wdata[30:0];
            sdls_pkg::CsrMapWidth:  map_width_ff  <= csr_wdata[8:0];
            sdls_pkg::CsrMapHeight: map_height_ff <= csr_wdata[8:0];
            default: ;
         endcase
      end
   end

   logic [8:0] dim_w, dim_h;
   assign dim_w = (map_width_ff  > MaxDim) ? MaxDim : map_width_ff;
   assign dim_h = (map_height_ff > MaxDim) ? MaxDim : map_height_ff;

   // global advance
   logic adv, rsp_load, last_sample;

   // offset stage
   sdls_pkg::ctl_type s1_ff;
   logic [32:0] s1_offx_ff, s1_offz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.v <= 1'b0;
      end else if (adv) begin
         s1_ff.v <= req_valid;
      end
      if (adv) begin
         s1_ff.op     <= req_data.operation;
         s1_ff.hit    <= 1'b0;
         s1_ff.idx    <= req_data.texel_index;
         s1_ff.rgba   <= req_data.texel_rgba;
         s1_offx_ff   <= {req_data.world_x[31], req_data.world_x}
                         - {origin_x_ff[31], origin_x_ff};
         s1_offz_ff   <= {req_data.world_z[31], req_data.world_z}
                         - {origin_z_ff[31], origin_z_ff};
      end
   end

   // multiply stage feeds divide stage 0
   sdls_pkg::ctl_type d_ctl_ff [0:CoordBits];
   logic [39:0]       d_remx_ff [0:CoordBits];
   logic [39:0]       d_remz_ff [0:CoordBits];
   logic [8:0]        d_qx_ff   [0:CoordBits];
   logic [8:0]        d_qz_ff   [0:CoordBits];
   logic              s1_inside;

   assign s1_inside = (world_size_ff != '0) && (dim_w != '0) && (dim_h != '0)
                      && !s1_offx_ff[32] && !s1_offz_ff[32]
                      && (s1_offx_ff[31:0] <= {1'b0, world_size_ff})
                      && (s1_offz_ff[31:0] <= {1'b0, world_size_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         d_ctl_ff[0].v <= 1'b0;
      end else if (adv) begin
         d_ctl_ff[0].v <= s1_ff.v;
      end
      if (adv) begin
         d_ctl_ff[0].op     <= s1_ff.op;
         d_ctl_ff[0].hit    <= s1_inside;
         d_ctl_ff[0].idx    <= s1_ff.idx;
         d_ctl_ff[0].rgba   <= s1_ff.rgba;
         d_remx_ff[0]       <= 40'(s1_offx_ff[30:0]) * 40'(dim_w);
         d_remz_ff[0]       <= 40'(s1_offz_ff[30:0]) * 40'(dim_h);
         d_qx_ff[0]         <= '0;
         d_qz_ff[0]         <= '0;
      end
   end

   for (genvar i = 0; i < CoordBits; i++) begin : g_coord_div
      localparam int Shift = CoordBits - 1 - i;
      logic [39:0] dsr;
      logic        gex, gez;
      assign dsr = {9'd0, world_size_ff} << Shift;
      assign gex = d_remx_ff[i] >= dsr;
      assign gez = d_remz_ff[i] >= dsr;

      always_ff @(posedge clock) begin
         if (reset) begin
            d_ctl_ff[i+1].v <= 1'b0;
         end else if (adv) begin
            d_ctl_ff[i+1].v <= d_ctl_ff[i].v;
         end
         if (adv) begin
            d_ctl_ff[i+1].op     <= d_ctl_ff[i].op;
            d_ctl_ff[i+1].hit    <= d_ctl_ff[i].hit;
            d_ctl_ff[i+1].idx    <= d_ctl_ff[i].idx;
            d_ctl_ff[i+1].rgba   <= d_ctl_ff[i].rgba;
            d_remx_ff[i+1]       <= gex ? d_remx_ff[i] - dsr : d_remx_ff[i];
            d_remz_ff[i+1]       <= gez ? d_remz_ff[i] - dsr : d_remz_ff[i];
            d_qx_ff[i+1]         <= {d_qx_ff[i][7:0], gex};
            d_qz_ff[i+1]         <= {d_qz_ff[i][7:0], gez};
         end
      end
   end

   // address stage
   sdls_pkg::ctl_type a_ctl_ff;
   logic [15:0]       a_addr_ff;
   logic [8:0]        tx, ty;
   logic [17:0]       lin;

   assign tx  = (d_qx_ff[CoordBits] >= dim_w) ? dim_w - 9'd1 : d_qx_ff[CoordBits];
   assign ty  = (d_qz_ff[CoordBits] >= dim_h) ? dim_h - 9'd1 : d_qz_ff[CoordBits];
   assign lin = 18'(ty) * 18'(dim_w) + 18'(tx);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ctl_ff.v <= 1'b0;
      end else if (adv) begin
         a_ctl_ff.v <= d_ctl_ff[CoordBits].v;
      end
      if (adv) begin
         a_ctl_ff.op     <= d_ctl_ff[CoordBits].op;
         a_ctl_ff.hit    <= d_ctl_ff[CoordBits].hit;
         a_ctl_ff.idx    <= d_ctl_ff[CoordBits].idx;
         a_ctl_ff.rgba   <= d_ctl_ff[CoordBits].rgba;
         a_addr_ff       <= (d_ctl_ff[CoordBits].op == sdls_pkg::OpWrite)
                            ? d_ctl_ff[CoordBits].idx : lin[15:0];
      end
   end

   // store access stage
   logic        ram_we, ram_re;
   logic [31:0] ram_rdata;
   sdls_pkg::ctl_type r_ctl_ff;

   assign ram_we = adv && a_ctl_ff.v && (a_ctl_ff.op == sdls_pkg::OpWrite);
   assign ram_re = adv && a_ctl_ff.v && (a_ctl_ff.op == sdls_pkg::OpSample)
                   && a_ctl_ff.hit;

   sdls_ram #(.WIDTH(32), .DEPTH(65536)) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (a_addr_ff),
      .wdata (a_ctl_ff.rgba),
      .re    (ram_re),
      .raddr (a_addr_ff),
      .rdata (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         r_ctl_ff.v <= 1'b0;
      end else if (adv) begin
         r_ctl_ff.v <= a_ctl_ff.v;
      end
      if (adv) begin
         r_ctl_ff.op     <= a_ctl_ff.op;
         r_ctl_ff.hit    <= a_ctl_ff.hit;
         r_ctl_ff.idx    <= a_ctl_ff.idx;
         r_ctl_ff.rgba   <= a_ctl_ff.rgba;
      end
   end

   // channel compare; ties keep the lower channel
   logic [7:0] ch0, ch1, ch2, ch3, mx01, mx23, mx;
   logic [1:0] ly01, ly23, ly;
   logic [9:0] csum;

   assign ch0  = r_ctl_ff.hit ? ram_rdata[7:0]   : 8'd0;
   assign ch1  = r_ctl_ff.hit ? ram_rdata[15:8]  : 8'd0;
   assign ch2  = r_ctl_ff.hit ? ram_rdata[23:16] : 8'd0;
   assign ch3  = r_ctl_ff.hit ? ram_rdata[31:24] : 8'd0;
   assign mx01 = (ch1 > ch0) ? ch1 : ch0;
   assign ly01 = (ch1 > ch0) ? 2'd1 : 2'd0;
   assign mx23 = (ch3 > ch2) ? ch3 : ch2;
   assign ly23 = (ch3 > ch2) ? 2'd3 : 2'd2;
   assign mx   = (mx23 > mx01) ? mx23 : mx01;
   assign ly   = (mx23 > mx01) ? ly23 : ly01;
   assign csum = 10'(ch0) + 10'(ch1) + 10'(ch2) + 10'(ch3);

   // weight divide stages
   logic [WeightBits:0] w_v_ff;
   logic [WeightBits:0] w_op_ff;
   logic [WeightBits:0] w_in_ff;
   logic [1:0]          w_layer_ff [0:WeightBits];
   logic [9:0]          w_sum_ff   [0:WeightBits];
   logic [26:0]         w_rem_ff   [0:WeightBits];
   logic [16:0]         w_q_ff     [0:WeightBits];

   always_ff @(posedge clock) begin
      if (reset) begin
         w_v_ff[0] <= 1'b0;
      end else if (adv) begin
         w_v_ff[0] <= r_ctl_ff.v;
      end
      if (adv) begin
         w_op_ff[0]    <= r_ctl_ff.op;
         w_in_ff[0]    <= r_ctl_ff.hit;
         w_layer_ff[0] <= ly;
         w_sum_ff[0]   <= csum;
         w_rem_ff[0]   <= {3'd0, mx, 16'd0};
         w_q_ff[0]     <= '0;
      end
   end

   for (genvar i = 0; i < WeightBits; i++) begin : g_weight_div
      localparam int Shift = WeightBits - 1 - i;
      logic [26:0] dsr;
      logic        ge;
      assign dsr = {17'd0, w_sum_ff[i]} << Shift;
      assign ge  = w_rem_ff[i] >= dsr;

      always_ff @(posedge clock) begin
         if (reset) begin
            w_v_ff[i+1] <= 1'b0;
         end else if (adv) begin
            w_v_ff[i+1] <= w_v_ff[i];
         end
         if (adv) begin
            w_op_ff[i+1]    <= w_op_ff[i];
            w_in_ff[i+1]    <= w_in_ff[i];
            w_layer_ff[i+1] <= w_layer_ff[i];
            w_sum_ff[i+1]   <= w_sum_ff[i];
            w_rem_ff[i+1]   <= ge ? w_rem_ff[i] - dsr : w_rem_ff[i];
            w_q_ff[i+1]     <= {w_q_ff[i][15:0], ge};
         end
      end
   end

   // output register
   sdls_pkg::rsp_type rsp_ff, rsp_in;
   logic              rsp_valid_ff;

   assign last_sample = w_v_ff[WeightBits] && (w_op_ff[WeightBits] == sdls_pkg::OpSample);
   assign rsp_load    = !rsp_valid_ff || rsp_ready;
   assign adv         = rsp_load || !last_sample;
   assign req_ready   = adv;

   assign rsp_in.inside_res      = w_in_ff[WeightBits];
   assign rsp_in.dominant_layer  = w_layer_ff[WeightBits];
   assign rsp_in.dominant_weight = (w_sum_ff[WeightBits] != '0) ? w_q_ff[WeightBits] : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= last_sample;
      end
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_store_port: assert property (@(posedge clock) disable iff (reset)
      !(ram_we && ram_re))
      else $error("store written and read in one cycle");

   a_weight_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_ff.dominant_weight <= 17'd65536)
      else $error("weight above one");

   a_outside_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.inside_res |->
         rsp_ff.dominant_layer == 2'd0 && rsp_ff.dominant_weight == 17'd0)
      else $error("outside sample with nonzero result");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(w_q_ff[WeightBits]) && $stable(rsp_ff))
      else $error("pipeline moved during stall");

endmodule
`default_nettype wire

// File: src/sdls_ram.sv
// Generic single write, single read RAM with registered read data.
// No dependencies.
`default_nettype none
module sdls_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 65536
) (
   input  wire                       clock,
   input  wire                       we,
   input  wire [$clog2(DEPTH)-1:0]   waddr,
   input  wire [WIDTH-1:0]           wdata,
   input  wire                       re,
   input  wire [$clog2(DEPTH)-1:0]   raddr,
   output logic [WIDTH-1:0]          rdata
);
   logic [WIDTH-1:0] mem [0:DEPTH-1];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule
`default_nettype wire
